@@ rtl/pqa_pkg.sv @@
`default_nettype none
package pqa_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam logic [3:0]  MAX_PRIO_RESET  = 4'd10;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_PRIO_HIGH = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
    logic [3:0]         priority_req;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } out_t;

  typedef struct packed {
    logic [3:0]         prio;
    logic signed [31:0] value;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/priority_queue_with_aging.sv @@
// Sorted queue kept in one single-port-read memory, front entry at address 0.
// Enqueue shifts each lower-priority entry back by one address before writing the new entry;
// dequeue takes the front entry and shifts the other occupancy-1 entries forward.
// Each shifted entry costs one memory read and one write-back.
// Rejected or empty-queue transactions go straight to the output state. One item at a time.
// Synchronous active-low reset: queue empty, priority limit = 10.
`default_nettype none
module priority_queue_with_aging #(
  parameter int unsigned QUEUE_DEPTH = pqa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire pqa_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output pqa_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_wdata
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ENQ_RD, S_ENQ_CHK, S_DEQ_V, S_DEQ_RD, S_DEQ_WR, S_OUT
  } state_t;

  state_t          state_r;
  logic [3:0]      max_prio_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   k_r;
  pqa_pkg::entry_t new_r;
  pqa_pkg::out_t   res_r;
  pqa_pkg::out_t   out_r;
  logic            out_valid_r;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  pqa_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_raddr;
  pqa_pkg::entry_t mem_rdata;
  logic [CW-1:0]   k_dec;
  logic [3:0]      aged_prio;

  assign k_dec     = k_r - CW'(1);
  assign aged_prio = (mem_rdata.prio < max_prio_r) ? mem_rdata.prio + 4'd1 : mem_rdata.prio;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  pqa_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_r[AW-1:0];
    mem_wdata = new_r;
    mem_raddr = '0;
    case (state_r)
      S_ENQ_RD: begin
        mem_raddr = k_dec[AW-1:0];
        if (k_r == '0) begin
          mem_we = 1'b1;
        end
      end
      S_ENQ_CHK: begin
        mem_we = 1'b1;
        if (mem_rdata.prio < new_r.prio) begin
          mem_wdata = mem_rdata;
        end
      end
      S_DEQ_RD: mem_raddr = k_r[AW-1:0];
      S_DEQ_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = k_dec[AW-1:0];
        mem_wdata.prio = aged_prio;
        mem_wdata.value = mem_rdata.value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_prio_r  <= pqa_pkg::MAX_PRIO_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_prio_r <= cfg_wdata;
      end
      // S_OUT drives out_valid_r itself
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            new_r.value <= in_data.value;
            new_r.prio  <= in_data.priority_req;
            res_r.result_value <= '0;
            res_r.occupancy    <= 5'(count_r);
            res_r.status       <= pqa_pkg::ST_OK;
            if (in_data.command == pqa_pkg::CMD_ENQ) begin
              if (in_data.priority_req > max_prio_r) begin
                res_r.status <= pqa_pkg::ST_PRIO_HIGH;
                state_r      <= S_OUT;
              end else if (count_r == CW'(QUEUE_DEPTH)) begin
                res_r.status <= pqa_pkg::ST_FULL;
                state_r      <= S_OUT;
              end else begin
                k_r     <= count_r;
                state_r <= S_ENQ_RD;
              end
            end else if (count_r == '0) begin
              res_r.status <= pqa_pkg::ST_EMPTY;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_DEQ_V;
            end
          end
        end
        S_ENQ_RD: begin
          if (k_r == '0) begin
            count_r         <= count_r + CW'(1);
            res_r.occupancy <= 5'(count_r + CW'(1));
            state_r         <= S_OUT;
          end else begin
            state_r <= S_ENQ_CHK;
          end
        end
        S_ENQ_CHK: begin
          if (mem_rdata.prio < new_r.prio) begin
            k_r     <= k_dec;
            state_r <= S_ENQ_RD;
          end else begin
            count_r         <= count_r + CW'(1);
            res_r.occupancy <= 5'(count_r + CW'(1));
            state_r         <= S_OUT;
          end
        end
        S_DEQ_V: begin
          res_r.result_value <= mem_rdata.value;
          k_r                <= CW'(1);
          state_r            <= S_DEQ_RD;
        end
        S_DEQ_RD: begin
          if (k_r == count_r) begin
            count_r         <= k_dec;
            res_r.occupancy <= 5'(k_dec);
            state_r         <= S_OUT;
          end else begin
            state_r <= S_DEQ_WR;
          end
        end
        S_DEQ_WR: begin
          k_r     <= k_r + CW'(1);
          state_r <= S_DEQ_RD;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/pqa_mem.sv @@
`default_nettype none
module pqa_mem #(
  parameter int unsigned QUEUE_DEPTH = pqa_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire pqa_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output pqa_pkg::entry_t      rdata_r
);

  pqa_pkg::entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire
